// ----- hdl/ptcal_pkg.sv -----
// Package for the two-point pressure calibration block with window averaging.
// Holds field widths, calibration constants, register indexes and the divider request type.
// No dependencies.
`default_nettype none

package ptcal_pkg;

  localparam int SAMPLE_W = 12;
  localparam int PRESS_W  = 16;
  localparam int SUM_W    = 18;
  localparam int GAIN_W   = 16;
  localparam int LINE_W   = 30;
  localparam int DVD_W    = 28;
  localparam int DVS_W    = 16;
  localparam int STEP_W   = 5;
  localparam int CFG_IDX_W = 1;

  localparam int SPAN_UNITS      = 40000;
  localparam int LOW_POINT_UNITS = 20000;
  localparam int SCALE_DIV       = 1000;
  localparam int WINDOW_DEF      = 4;

  localparam int GAIN_STEPS = GAIN_W;

  // A non-negative line value has at most DVD_W bits, so a rounded-up reciprocal of
  // DVD_W + 1 bits with this shift gives the exact quotient by SCALE_DIV.
  localparam int SCALE_SH      = DVD_W + $clog2(SCALE_DIV);
  localparam int SCALE_RECIP_W = DVD_W + 1;
  localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP = SCALE_RECIP_W'(
    ((64'd1 << SCALE_SH) + 64'(SCALE_DIV) - 64'd1) / 64'(SCALE_DIV));

  localparam logic [SAMPLE_W-1:0] CAL_HIGH_RST = '1;
  localparam logic [SAMPLE_W-1:0] CAL_LOW_RST  = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_HIGH = 1'b0,
    REG_CAL_LOW  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- hdl/ptcal_if.sv -----
// Valid/ready channel interfaces for samples, results and configuration writes.
// Depends on ptcal_pkg for payload widths.
`default_nettype none

interface ptcal_in_if import ptcal_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface ptcal_out_if import ptcal_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRESS_W-1:0] pressure;
  logic               updated;
  logic               cal_fault;

  modport source (output valid, output pressure, output updated, output cal_fault, input ready);
  modport sink (input valid, input pressure, input updated, input cal_fault, output ready);
endinterface

interface ptcal_cfg_if import ptcal_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SAMPLE_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/ptcal_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
// Depends on ptcal_pkg for operand widths and the request and status types.
`default_nettype none

module ptcal_div import ptcal_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire div_req_t         req_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output div_stat_t             stat_o,
  output logic [DVD_W-1:0]      quotient_o
);

  logic [DVD_W-1:0]  dvd_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVD_W-1:0]  quo_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DVS_W:0]    rem_sh;
  logic              fits;

  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= dividend_i << (STEP_W'(DVD_W) - req_i.steps);
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      quo_q <= {quo_q[DVD_W-2:0], fits};
      if (fits) begin
        rem_q <= DVS_W'(rem_sh - {1'b0, dvs_q});
      end else begin
        rem_q <= rem_sh[DVS_W-1:0];
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

`default_nettype wire

// ----- hdl/pressure_two_point_cal_block_avg.sv -----
// Top level of the two-point pressure calibration block with window averaging.
// Depends on ptcal_pkg, the channel interfaces in ptcal_if and the divider ptcal_div.
//
//   Channel  Dir  Payload                              Handshake
//   in_i     in   sample[11:0]                         valid/ready
//   out_o    out  pressure[15:0], updated, cal_fault   valid/ready
//   cfg_i    in   index[0], data[11:0]                 valid/ready, always ready
//
// Once a sample is accepted, the input is ready again only after the gain division (16 divider
// steps), the multiply, offset, scaling, accumulate and output states, and the averaging state
// when the sample closes a window. The scaled line value and the window average are reciprocal
// multiplications. A faulty calibration skips the divider; a negative line value skips scaling.
// The result waits in an output register, so the next sample is taken before it is read;
// the sequencer stalls in its last state while that register still holds an unread result.
// Reset clears the window sum, the window count and the held pressure.
`default_nettype none

module pressure_two_point_cal_block_avg import ptcal_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  ptcal_in_if.sink        in_i,
  ptcal_out_if.source     out_o,
  ptcal_cfg_if.sink       cfg_i
);

  localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  localparam int SCALE_PROD_W = SCALE_SH + PRESS_W;
  localparam int AVG_SH       = SUM_W + $clog2(WINDOW);
  localparam int AVG_W        = AVG_SH + PRESS_W;
  localparam int AVG_RECIP_W  = SUM_W + 1;
  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = AVG_RECIP_W'(
    ((64'd1 << AVG_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN,
    ST_MUL,
    ST_OFS,
    ST_LINE,
    ST_ACC,
    ST_AVG,
    ST_DONE
  } state_e;

  state_e             state_q;
  logic [SAMPLE_W-1:0] cal_high_q;
  logic [SAMPLE_W-1:0] cal_low_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [GAIN_W-1:0]   gain_q;
  logic [LINE_W-1:0]   prod_q;
  logic [DVD_W-1:0]    line_q;
  logic [PRESS_W-1:0]  contrib_q;
  logic [SUM_W-1:0]    sum_q;
  logic [CNT_W-1:0]    count_q;
  logic [PRESS_W-1:0]  held_q;
  logic                fault_q;
  logic                upd_q;
  logic                out_valid_q;
  logic [PRESS_W-1:0]  out_press_q;
  logic                out_upd_q;
  logic                out_fault_q;

  div_req_t            div_req_q;
  logic [DVD_W-1:0]    div_dvd_q;
  logic [DVS_W-1:0]    div_dvs_q;
  div_stat_t           div_stat;
  logic [DVD_W-1:0]    div_quo;

  logic                in_acc;
  logic                out_acc;
  logic signed [SAMPLE_W:0] diff_s;
  logic [LINE_W-1:0]   line_w;
  logic [SUM_W-1:0]    sum_n;
  logic [SCALE_PROD_W-1:0] scaled_w;
  logic [AVG_W-1:0]    avg_w;

  ptcal_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req_q),
    .dividend_i (div_dvd_q),
    .divisor_i  (div_dvs_q),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_acc     = out_valid_q && out_o.ready;

  assign diff_s   = $signed({1'b0, sample_q}) - $signed({1'b0, cal_low_q});
  assign line_w   = prod_q + LINE_W'(LOW_POINT_UNITS);
  assign sum_n    = sum_q + SUM_W'(contrib_q);
  assign scaled_w = SCALE_PROD_W'(line_q) * SCALE_PROD_W'(SCALE_RECIP);
  assign avg_w    = AVG_W'(sum_q) * AVG_W'(AVG_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_high_q <= CAL_HIGH_RST;
      cal_low_q  <= CAL_LOW_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_CAL_HIGH: cal_high_q <= cfg_i.data;
        REG_CAL_LOW:  cal_low_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_req_q   <= '0;
      div_dvd_q   <= '0;
      div_dvs_q   <= '0;
      sample_q    <= '0;
      gain_q      <= '0;
      prod_q      <= '0;
      line_q      <= '0;
      contrib_q   <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      held_q      <= '0;
      fault_q     <= 1'b0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_press_q <= '0;
      out_upd_q   <= 1'b0;
      out_fault_q <= 1'b0;
    end else begin
      div_req_q.start <= 1'b0;
      if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            sample_q <= in_i.sample;
            if (cal_high_q > cal_low_q) begin
              fault_q         <= 1'b0;
              div_dvd_q       <= DVD_W'(SPAN_UNITS);
              div_dvs_q       <= DVS_W'(cal_high_q - cal_low_q);
              div_req_q.start <= 1'b1;
              div_req_q.steps <= STEP_W'(GAIN_STEPS);
              state_q         <= ST_GAIN;
            end else begin
              fault_q <= 1'b1;
              gain_q  <= '0;
              state_q <= ST_MUL;
            end
          end
        end
        ST_GAIN: begin
          if (div_stat.done) begin
            gain_q  <= div_quo[GAIN_W-1:0];
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= LINE_W'($signed({1'b0, gain_q}) * diff_s);
          state_q <= ST_OFS;
        end
        ST_OFS: begin
          if (line_w[LINE_W-1]) begin
            contrib_q <= '0;
            state_q   <= ST_ACC;
          end else begin
            line_q  <= line_w[DVD_W-1:0];
            state_q <= ST_LINE;
          end
        end
        ST_LINE: begin
          contrib_q <= scaled_w[SCALE_SH +: PRESS_W];
          state_q   <= ST_ACC;
        end
        ST_ACC: begin
          sum_q <= sum_n;
          if (count_q == CNT_W'(WINDOW - 1)) begin
            count_q <= '0;
            upd_q   <= 1'b1;
            state_q <= ST_AVG;
          end else begin
            count_q <= count_q + 1'b1;
            upd_q   <= 1'b0;
            state_q <= ST_DONE;
          end
        end
        ST_AVG: begin
          held_q  <= avg_w[AVG_SH +: PRESS_W];
          sum_q   <= '0;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_press_q <= held_q;
            out_upd_q   <= upd_q;
            out_fault_q <= fault_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pressure  = out_press_q;
  assign out_o.updated   = out_upd_q;
  assign out_o.cal_fault = out_fault_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_GAIN))
    else $error("divider finished outside the gain wait state");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(WINDOW - 1))
    else $error("window count beyond window length");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("accepted sample did not start the sequencer");

  a_avg_marks_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_AVG |-> upd_q)
    else $error("window average without update flag");

  a_no_start_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_q.start |-> !div_stat.busy)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire
